// ----- rtl/uer_pkg.sv -----
// Package for the ultrasonic echo ranger: register map, reset values,
// status codes, scaling constants and the shared struct types.
// No dependencies.
package uer_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int TICK_BITS = 16;
  localparam int DIST_BITS = 18;
  localparam int MUL_BITS = 14;
  localparam int DIST_SHIFT = 12;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [MUL_BITS-1:0] DIST_MUL = 14'd11227;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 18'd262143;

  localparam logic [TICK_BITS-1:0] TRIGGER_RST = 16'd20;
  localparam logic [TICK_BITS-1:0] TIMEOUT_RST = 16'd65530;
  localparam logic [DIST_BITS-1:0] BAND_LOW_RST = 18'd4800;
  localparam logic [DIST_BITS-1:0] BAND_HIGH_RST = 18'd6400;
  localparam logic [DIST_BITS-1:0] MAX_DIST_RST = 18'd120000;

  typedef enum logic [2:0] {
    REG_TRIGGER   = 3'd0,
    REG_TIMEOUT   = 3'd1,
    REG_BAND_LOW  = 3'd2,
    REG_BAND_HIGH = 3'd3,
    REG_MAX_DIST  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_IN_BAND = 2'd1,
    ST_OVER    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] trigger_ticks;
    logic [TICK_BITS-1:0] timeout_ticks;
    logic [DIST_BITS-1:0] band_low;
    logic [DIST_BITS-1:0] band_high;
    logic [DIST_BITS-1:0] max_distance;
  } cfg_t;

  typedef struct packed {
    logic trig;
    logic done;
    logic tmo;
  } seq_flags_t;

endpackage

// ----- rtl/uer_regs.sv -----
// Configuration register bank of the echo ranger behind an APB-style port.
// Depends on uer_pkg for the register map, reset values and cfg_t.
module uer_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [uer_pkg::ADDR_BITS-1:0] paddr,
  input  logic [uer_pkg::DATA_BITS-1:0] pwdata,
  output logic [uer_pkg::DATA_BITS-1:0] prdata,
  output logic                         pready,
  output uer_pkg::cfg_t                cfg
);
  import uer_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks <= TRIGGER_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.band_low      <= BAND_LOW_RST;
      cfg_r.band_high     <= BAND_HIGH_RST;
      cfg_r.max_distance  <= MAX_DIST_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRIGGER:   cfg_r.trigger_ticks <= pwdata[TICK_BITS-1:0];
        REG_TIMEOUT:   cfg_r.timeout_ticks <= pwdata[TICK_BITS-1:0];
        REG_BAND_LOW:  cfg_r.band_low      <= pwdata[DIST_BITS-1:0];
        REG_BAND_HIGH: cfg_r.band_high     <= pwdata[DIST_BITS-1:0];
        REG_MAX_DIST:  cfg_r.max_distance  <= pwdata[DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRIGGER:   prdata = DATA_BITS'(cfg_r.trigger_ticks);
      REG_TIMEOUT:   prdata = DATA_BITS'(cfg_r.timeout_ticks);
      REG_BAND_LOW:  prdata = DATA_BITS'(cfg_r.band_low);
      REG_BAND_HIGH: prdata = DATA_BITS'(cfg_r.band_high);
      REG_MAX_DIST:  prdata = DATA_BITS'(cfg_r.max_distance);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/uer_seq.sv -----
// Measurement sequencer: trigger pulse, wait for echo rise, echo width count.
// Takes one tick per transfer and registers the flags and width for the next stage.
// Depends on uer_pkg for cfg_t and seq_flags_t.
module uer_seq #(
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  uer_pkg::cfg_t           cfg,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic                    start_req,
  input  logic                    echo_level,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output uer_pkg::seq_flags_t     dn_flags,
  output logic [COUNTER_BITS-1:0] dn_width
);
  import uer_pkg::*;

  localparam int TW = (COUNTER_BITS > TICK_BITS) ? COUNTER_BITS : TICK_BITS;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TRIGGER = 2'd1,
    PH_WAIT    = 2'd2,
    PH_MEASURE = 2'd3
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNTER_BITS-1:0] cnt_inc, trig_cnt;
  logic                    cnt_full, wait_fail, trig_end, first_end, fire;
  logic                    dn_valid_r;
  seq_flags_t              flags_r, flags_nxt;
  logic [COUNTER_BITS-1:0] width_r;

  assign up_ready  = !dn_valid_r || dn_ready;
  assign fire      = up_valid && up_ready;
  assign dn_valid  = dn_valid_r;
  assign dn_flags  = flags_r;
  assign dn_width  = width_r;

  assign cnt_inc   = cnt_r + 1'b1;
  assign cnt_full  = &cnt_r;
  assign wait_fail = cnt_full || (TW'(cnt_r) >= TW'(cfg.timeout_ticks));
  assign trig_cnt  = cnt_full ? cnt_r : cnt_inc;
  assign trig_end  = (&trig_cnt) || (TW'(trig_cnt) >= TW'(cfg.trigger_ticks));
  assign first_end = TW'(1) >= TW'(cfg.trigger_ticks);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    flags_nxt = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          flags_nxt.trig = 1'b1;
          if (first_end) begin
            phase_nxt = PH_WAIT;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_TRIGGER;
            cnt_nxt   = COUNTER_BITS'(1);
          end
        end
      end
      PH_TRIGGER: begin
        flags_nxt.trig = 1'b1;
        if (trig_end) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = trig_cnt;
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          if (cfg.timeout_ticks == '0) begin
            flags_nxt.done = 1'b1;
            flags_nxt.tmo  = 1'b1;
            phase_nxt      = PH_IDLE;
            cnt_nxt        = '0;
          end else begin
            phase_nxt = PH_MEASURE;
            cnt_nxt   = COUNTER_BITS'(1);
          end
        end else if (wait_fail) begin
          flags_nxt.done = 1'b1;
          flags_nxt.tmo  = 1'b1;
          phase_nxt      = PH_IDLE;
          cnt_nxt        = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_MEASURE: begin
        if (echo_level) begin
          if (wait_fail) begin
            flags_nxt.done = 1'b1;
            flags_nxt.tmo  = 1'b1;
            phase_nxt      = PH_IDLE;
            cnt_nxt        = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          flags_nxt.done = 1'b1;
          phase_nxt      = PH_IDLE;
          cnt_nxt        = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      dn_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        dn_valid_r <= up_valid;
      end
      if (fire) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      flags_r <= flags_nxt;
      width_r <= cnt_r;
    end
  end

endmodule

// ----- rtl/uer_scale.sv -----
// Distance scaling and classification: a product stage, then the output register.
// Distance is (width * 11227) >> 12 in 1/16 mm, saturated to the field width.
// Depends on uer_pkg for the constants, cfg_t, seq_flags_t and status_t.
module uer_scale #(
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  uer_pkg::cfg_t                cfg,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  uer_pkg::seq_flags_t          up_flags,
  input  logic [COUNTER_BITS-1:0]      up_width,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_trig_level,
  output logic                         out_done_res,
  output logic [1:0]                   out_status,
  output logic [uer_pkg::DIST_BITS-1:0] out_distance
);
  import uer_pkg::*;

  localparam int PW = COUNTER_BITS + MUL_BITS;
  localparam int DW = PW - DIST_SHIFT;
  localparam int CW = (DW > DIST_BITS) ? DW : DIST_BITS;

  logic                 prod_v_r;
  seq_flags_t           prod_flags_r;
  logic [PW-1:0]        prod_r;
  logic                 out_v_r;
  logic                 out_en, prod_en;
  logic [CW-1:0]        dist_ext;
  status_t              status_nxt;
  logic [DIST_BITS-1:0] dist_nxt;
  logic                 trig_r, done_r;
  status_t              status_r;
  logic [DIST_BITS-1:0] dist_r;

  assign out_en   = !out_v_r || out_ready;
  assign prod_en  = !prod_v_r || out_en;
  assign up_ready = prod_en;

  assign dist_ext = CW'(prod_r[PW-1:DIST_SHIFT]);

  always_comb begin
    status_nxt = ST_NORMAL;
    dist_nxt   = '0;
    if (prod_flags_r.done) begin
      if (prod_flags_r.tmo) begin
        status_nxt = ST_TIMEOUT;
      end else begin
        if (dist_ext > CW'(cfg.max_distance)) begin
          status_nxt = ST_OVER;
        end else if ((dist_ext > CW'(cfg.band_low)) && (dist_ext < CW'(cfg.band_high))) begin
          status_nxt = ST_IN_BAND;
        end
        dist_nxt = (dist_ext > CW'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_v_r <= up_valid;
      end
      if (out_en) begin
        out_v_r <= prod_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en && up_valid) begin
      prod_flags_r <= up_flags;
      prod_r       <= PW'(up_width) * PW'(DIST_MUL);
    end
    if (out_en && prod_v_r) begin
      trig_r   <= prod_flags_r.trig;
      done_r   <= prod_flags_r.done;
      status_r <= status_nxt;
      dist_r   <= dist_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_trig_level = trig_r;
  assign out_done_res   = done_r;
  assign out_status     = status_r;
  assign out_distance   = dist_r;

endmodule

// ----- rtl/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger: input register, sequencer, scaling stage.
// Depends on uer_pkg, uer_regs, uer_seq and uer_scale.
//
// Each input transfer is one microsecond tick carrying a start request and the
// sampled echo level, and each produces exactly one result transfer with the
// trigger level, a done flag, a status and a distance in 1/16 mm. The block
// sustains one tick per clock cycle while the result side is not stalled; a tick
// passes through the input register, sequencer register, product register and
// output register; back pressure on the result side stalls the whole pipeline.
// The tick counter is COUNTER_BITS wide and only the sequencer stage carries
// state from one tick to the next. Configuration is to be written through the
// APB port only while no tick is in flight; the block itself does not enforce
// this. Registers lie at byte addresses 0, 4, 8, 12 and 16 in the order
// trigger_ticks, timeout_ticks, band_low, band_high, max_distance.
module ultrasonic_echo_ranger #(
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [uer_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [uer_pkg::DATA_BITS-1:0] cfg_pwdata,
  output logic [uer_pkg::DATA_BITS-1:0] cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_start_req,
  input  logic                          in_echo_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_trig_level,
  output logic                          out_done_res,
  output logic [1:0]                    out_status,
  output logic [uer_pkg::DIST_BITS-1:0] out_distance
);
  import uer_pkg::*;

  cfg_t                    cfg;
  logic                    in_v_r;
  logic                    start_r, echo_r;
  logic                    seq_ready;
  logic                    seq_valid, scale_ready;
  seq_flags_t              seq_flags;
  logic [COUNTER_BITS-1:0] seq_width;

  assign in_ready = !in_v_r || seq_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      start_r <= in_start_req;
      echo_r  <= in_echo_level;
    end
  end

  uer_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  uer_seq #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .up_valid   (in_v_r),
    .up_ready   (seq_ready),
    .start_req  (start_r),
    .echo_level (echo_r),
    .dn_valid   (seq_valid),
    .dn_ready   (scale_ready),
    .dn_flags   (seq_flags),
    .dn_width   (seq_width)
  );

  uer_scale #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .up_valid       (seq_valid),
    .up_ready       (scale_ready),
    .up_flags       (seq_flags),
    .up_width       (seq_width),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_trig_level (out_trig_level),
    .out_done_res   (out_done_res),
    .out_status     (out_status),
    .out_distance   (out_distance)
  );

endmodule

// ----- rtl/uer_chk.sv -----
// Port-level checker for the echo ranger result channel, bound to the top level.
// Depends on uer_pkg for the status codes and field widths.
module uer_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_trig_level,
  input logic                          out_done_res,
  input logic [1:0]                    out_status,
  input logic [uer_pkg::DIST_BITS-1:0] out_distance
);
  import uer_pkg::*;

  // A stalled result transfer keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_done_res) &&
      $stable(out_status) && $stable(out_distance) && $stable(out_trig_level))
    else $error("result changed while stalled");

  // The trigger is never driven on the tick a measurement finishes.
  a_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_trig_level && out_done_res))
    else $error("trigger and done together");

  // Without done, status and distance read as zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_NORMAL && out_distance == '0)
    else $error("status or distance without done");

  // A timeout reports no distance.
  a_tmo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TIMEOUT |-> out_done_res && out_distance == '0)
    else $error("timeout with distance");

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ultrasonic_echo_ranger uer_chk u_chk (.*);
